@@ design/evr_pkg.sv @@
// shared types, constants and helpers for the ellipsoid voxel relabel block
package evr_pkg;

   // field widths
   localparam int COORD_W = 9;
   localparam int LABEL_W = 8;
   localparam int SQ_W    = 2 * COORD_W;   // one squared coordinate or axis
   localparam int MUL_W   = SQ_W;          // shared multiplier operand width
   localparam int PROD_W  = 2 * MUL_W;
   localparam int ACC_W   = 56;            // sum of three 54-bit terms
   localparam int RHS_W   = 3 * SQ_W;      // a^2 * b^2 * c^2

   // grid extent along every axis
   localparam int GRID_SIZE = 512;

   // relabel target and eligible label set {1,2,3,4,6,9,10,11,12,14}
   localparam logic [LABEL_W-1:0] NEW_LABEL     = 8'd46;
   localparam logic [15:0]        ELIGIBLE_MASK = 16'h5E5E;

   // configuration register indexes
   localparam int CSR_ADDR_W = 3;
   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_CENTER_X    = 3'd0,
      CSR_CENTER_Y    = 3'd1,
      CSR_CENTER_Z    = 3'd2,
      CSR_SEMI_AXIS_X = 3'd3,
      CSR_SEMI_AXIS_Y = 3'd4,
      CSR_SEMI_AXIS_Z = 3'd5
   } csr_addr_type;

   typedef logic [COORD_W-1:0] coord_type;
   typedef logic [MUL_W-1:0]   mul_op_type;
   typedef logic [PROD_W-1:0]  prod_type;

   // label is eligible when it is below 16 and its bit is set in the mask
   function automatic logic label_eligible(input logic [LABEL_W-1:0] label);
      logic res;
      res = 1'b0;
      if (label[LABEL_W-1:4] == '0) begin
         res = ELIGIBLE_MASK[label[3:0]];
      end
      return res;
   endfunction

   // absolute difference of two coordinates
   function automatic coord_type abs_diff(input coord_type p, input coord_type q);
      coord_type d;
      d = (p >= q) ? (p - q) : (q - p);
      return d;
   endfunction

endpackage

@@ design/evr_mul.sv @@
// shared unsigned multiplier with a registered product
module evr_mul (
   input  logic               clock,
   input  evr_pkg::mul_op_type op_a,
   input  evr_pkg::mul_op_type op_b,
   output evr_pkg::prod_type   prod
);
   import evr_pkg::*;

   prod_type prod_ff;
   prod_type prod_in;

   // one full-width product per cycle
   assign prod_in = PROD_W'(op_a) * PROD_W'(op_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

@@ design/ellipsoid_voxel_relabel_top.sv @@
// ellipsoid voxel relabel: point-in-ellipsoid test over a shared multiplier
//
//   channel  direction  bus                          meaning
//   req      in         tvalid/tready/tdata[39:0]    voxel and its current label
//   rsp      out        tvalid/tready/tdata[63:0]    new label and bounding box
//                       tuser[0]                     relabeled flag
//   csr      in         we/addr[2:0]/wdata[8:0]      ellipsoid center and semi-axes
//
// each voxel runs 17 products through the single 18x18 multiplier, then one
// flush, one compare and one result load; the next voxel is accepted only once
// the result load of the last one is done and the sequencer is back in idle.
// req_tready is high only while the sequencer is idle; a result waiting in the
// output register does not block acceptance of the next voxel, but the result
// load of that voxel waits until the output register is free.
// reset is synchronous: the box reads empty (min 511, max 0), center 0, axes 1.
module ellipsoid_voxel_relabel_top (
   input  logic        clock,
   input  logic        reset,
   // req: x [8:0], y [17:9], z [26:18], current_label [34:27]
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,
   // rsp: new_label [7:0], min_x [16:8], max_x [25:17], min_y [34:26],
   //      max_y [43:35], min_z [52:44], max_z [61:53]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,
   // rsp user: relabeled [0]
   output logic [0:0]  rsp_tuser,
   input  logic        csr_we,
   input  logic [evr_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [evr_pkg::COORD_W-1:0]    csr_wdata
);
   import evr_pkg::*;

   typedef enum logic [1:0] {
      IDLE,
      RUN,
      DONE
   } state_type;

   // multiplier schedule: one product issued per step, then a flush and a compare step
   typedef enum logic [4:0] {
      SQ_A, SQ_B, SQ_C, SQ_DX, SQ_DY, SQ_DZ,
      SQ_BC, SQ_AC, SQ_AB,
      SQ_XL, SQ_XH, SQ_YL, SQ_YH, SQ_ZL, SQ_ZH,
      SQ_RL, SQ_RH, SQ_FLUSH, SQ_CMP
   } step_type;

   state_type state_ff;
   step_type  step_ff;

   // configuration
   coord_type center_x_ff, center_y_ff, center_z_ff;
   coord_type axis_x_ff, axis_y_ff, axis_z_ff;

   // accepted voxel
   coord_type           vx_ff, vy_ff, vz_ff;
   logic [LABEL_W-1:0]  label_ff;

   // intermediate products
   logic [SQ_W-1:0]     a2_ff, b2_ff, c2_ff, dx2_ff, dy2_ff, dz2_ff;
   prod_type            bc_ff, ac_ff, ab_ff;
   logic [ACC_W-1:0]    acc_ff;
   logic [RHS_W-1:0]    rhs_ff;
   logic                hit_ff;

   // running bounding box
   coord_type box_min_x_ff, box_max_x_ff, box_min_y_ff;
   coord_type box_max_y_ff, box_min_z_ff, box_max_z_ff;
   coord_type box_min_x_in, box_max_x_in, box_min_y_in;
   coord_type box_max_y_in, box_min_z_in, box_max_z_in;

   // output register
   logic               rsp_valid_ff;
   logic [LABEL_W-1:0] rsp_label_ff;
   logic               rsp_flag_ff;
   coord_type rsp_min_x_ff, rsp_max_x_ff, rsp_min_y_ff;
   coord_type rsp_max_y_ff, rsp_min_z_ff, rsp_max_z_ff;

   mul_op_type op_a, op_b;
   prod_type   prod;
   logic       req_fire;
   logic       slot_free;
   logic       in_grid;
   logic       hit_in;

   assign req_tready = (state_ff == IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;

   // operand select for the shared multiplier
   always_comb begin
      op_a = '0;
      op_b = '0;
      case (step_ff)
         SQ_A: begin
            op_a = MUL_W'(axis_x_ff);
            op_b = MUL_W'(axis_x_ff);
         end
         SQ_B: begin
            op_a = MUL_W'(axis_y_ff);
            op_b = MUL_W'(axis_y_ff);
         end
         SQ_C: begin
            op_a = MUL_W'(axis_z_ff);
            op_b = MUL_W'(axis_z_ff);
         end
         SQ_DX: begin
            op_a = MUL_W'(abs_diff(vx_ff, center_x_ff));
            op_b = MUL_W'(abs_diff(vx_ff, center_x_ff));
         end
         SQ_DY: begin
            op_a = MUL_W'(abs_diff(vy_ff, center_y_ff));
            op_b = MUL_W'(abs_diff(vy_ff, center_y_ff));
         end
         SQ_DZ: begin
            op_a = MUL_W'(abs_diff(vz_ff, center_z_ff));
            op_b = MUL_W'(abs_diff(vz_ff, center_z_ff));
         end
         SQ_BC: begin
            op_a = b2_ff;
            op_b = c2_ff;
         end
         SQ_AC: begin
            op_a = a2_ff;
            op_b = c2_ff;
         end
         SQ_AB: begin
            op_a = a2_ff;
            op_b = b2_ff;
         end
         SQ_XL: begin
            op_a = dx2_ff;
            op_b = bc_ff[MUL_W-1:0];
         end
         SQ_XH: begin
            op_a = dx2_ff;
            op_b = bc_ff[PROD_W-1:MUL_W];
         end
         SQ_YL: begin
            op_a = dy2_ff;
            op_b = ac_ff[MUL_W-1:0];
         end
         SQ_YH: begin
            op_a = dy2_ff;
            op_b = ac_ff[PROD_W-1:MUL_W];
         end
         SQ_ZL: begin
            op_a = dz2_ff;
            op_b = ab_ff[MUL_W-1:0];
         end
         SQ_ZH: begin
            op_a = dz2_ff;
            op_b = ab_ff[PROD_W-1:MUL_W];
         end
         SQ_RL: begin
            op_a = a2_ff;
            op_b = bc_ff[MUL_W-1:0];
         end
         SQ_RH: begin
            op_a = a2_ff;
            op_b = bc_ff[PROD_W-1:MUL_W];
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   evr_mul u_mul (
      .clock (clock),
      .op_a  (op_a),
      .op_b  (op_b),
      .prod  (prod)
   );

   // voxel eligibility and the final inside test
   assign in_grid = (32'(vx_ff) < GRID_SIZE) && (32'(vy_ff) < GRID_SIZE)
                 && (32'(vz_ff) < GRID_SIZE);
   assign hit_in  = in_grid && label_eligible(label_ff)
                 && (acc_ff <= ACC_W'(rhs_ff));

   // box widened by the voxel when it is relabeled
   always_comb begin
      box_min_x_in = box_min_x_ff;
      box_max_x_in = box_max_x_ff;
      box_min_y_in = box_min_y_ff;
      box_max_y_in = box_max_y_ff;
      box_min_z_in = box_min_z_ff;
      box_max_z_in = box_max_z_ff;
      if (hit_ff) begin
         if (vx_ff < box_min_x_ff) box_min_x_in = vx_ff;
         if (vx_ff > box_max_x_ff) box_max_x_in = vx_ff;
         if (vy_ff < box_min_y_ff) box_min_y_in = vy_ff;
         if (vy_ff > box_max_y_ff) box_max_y_in = vy_ff;
         if (vz_ff < box_min_z_ff) box_min_z_in = vz_ff;
         if (vz_ff > box_max_z_ff) box_max_z_in = vz_ff;
      end
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff <= '0;
         center_y_ff <= '0;
         center_z_ff <= '0;
         axis_x_ff   <= COORD_W'(1);
         axis_y_ff   <= COORD_W'(1);
         axis_z_ff   <= COORD_W'(1);
      end else if (csr_we) begin
         case (csr_addr)
            CSR_CENTER_X:    center_x_ff <= csr_wdata;
            CSR_CENTER_Y:    center_y_ff <= csr_wdata;
            CSR_CENTER_Z:    center_z_ff <= csr_wdata;
            CSR_SEMI_AXIS_X: axis_x_ff   <= csr_wdata;
            CSR_SEMI_AXIS_Y: axis_y_ff   <= csr_wdata;
            CSR_SEMI_AXIS_Z: axis_z_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // product write-back, in the step after the issue
   always_ff @(posedge clock) begin
      if (state_ff == RUN) begin
         case (step_ff)
            SQ_B:     a2_ff  <= prod[SQ_W-1:0];
            SQ_C:     b2_ff  <= prod[SQ_W-1:0];
            SQ_DX:    c2_ff  <= prod[SQ_W-1:0];
            SQ_DY:    dx2_ff <= prod[SQ_W-1:0];
            SQ_DZ:    dy2_ff <= prod[SQ_W-1:0];
            SQ_BC:    dz2_ff <= prod[SQ_W-1:0];
            SQ_AC:    bc_ff  <= prod;
            SQ_AB:    ac_ff  <= prod;
            SQ_XL:    ab_ff  <= prod;
            SQ_XH:    acc_ff <= ACC_W'(prod);
            SQ_YL,
            SQ_ZL,
            SQ_RL:    acc_ff <= acc_ff + ACC_W'({prod, {MUL_W{1'b0}}});
            SQ_YH,
            SQ_ZH:    acc_ff <= acc_ff + ACC_W'(prod);
            SQ_RH:    rhs_ff <= RHS_W'(prod);
            SQ_FLUSH: rhs_ff <= rhs_ff + RHS_W'({prod, {MUL_W{1'b0}}});
            SQ_CMP:   hit_ff <= hit_in;
            default: ;
         endcase
      end
   end

   // sequencer, accepted voxel, box and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         step_ff      <= SQ_A;
         rsp_valid_ff <= 1'b0;
         box_min_x_ff <= '1;
         box_min_y_ff <= '1;
         box_min_z_ff <= '1;
         box_max_x_ff <= '0;
         box_max_y_ff <= '0;
         box_max_z_ff <= '0;
      end else begin
         // the result load below takes over the output register in its own cycle
         if (rsp_valid_ff && rsp_tready && state_ff != DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            IDLE: begin
               if (req_fire) begin
                  vx_ff    <= req_tdata[8:0];
                  vy_ff    <= req_tdata[17:9];
                  vz_ff    <= req_tdata[26:18];
                  label_ff <= req_tdata[34:27];
                  step_ff  <= SQ_A;
                  state_ff <= RUN;
               end
            end
            RUN: begin
               if (step_ff == SQ_CMP) begin
                  state_ff <= DONE;
               end else begin
                  step_ff <= step_type'(step_ff + 5'd1);
               end
            end
            DONE: begin
               // load the result once the output register is free
               if (slot_free) begin
                  box_min_x_ff <= box_min_x_in;
                  box_max_x_ff <= box_max_x_in;
                  box_min_y_ff <= box_min_y_in;
                  box_max_y_ff <= box_max_y_in;
                  box_min_z_ff <= box_min_z_in;
                  box_max_z_ff <= box_max_z_in;
                  rsp_label_ff <= hit_ff ? NEW_LABEL : label_ff;
                  rsp_flag_ff  <= hit_ff;
                  rsp_min_x_ff <= box_min_x_in;
                  rsp_max_x_ff <= box_max_x_in;
                  rsp_min_y_ff <= box_min_y_in;
                  rsp_max_y_ff <= box_max_y_in;
                  rsp_min_z_ff <= box_min_z_in;
                  rsp_max_z_ff <= box_max_z_in;
                  rsp_valid_ff <= 1'b1;
                  step_ff      <= SQ_A;
                  state_ff     <= IDLE;
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_flag_ff;
   assign rsp_tdata  = {2'b00, rsp_max_z_ff, rsp_min_z_ff, rsp_max_y_ff, rsp_min_y_ff,
                        rsp_max_x_ff, rsp_min_x_ff, rsp_label_ff};

   // a relabeled result always carries the new label
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[7:0] == NEW_LABEL)
      else $error("relabeled result without the new label");

   // a relabeled result always reports a non-empty box
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[16:8] <= rsp_tdata[25:17]
         && rsp_tdata[34:26] <= rsp_tdata[43:35] && rsp_tdata[52:44] <= rsp_tdata[61:53])
      else $error("relabeled result with an empty box");

   // the sequencer stays busy after taking a voxel
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("voxel accepted while a voxel is in work");

   // a new result appears only out of the result-load state
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff) == DONE)
      else $error("result raised outside the load step");

endmodule
